// File: rtl/core/script_lexer_unit_defines.svh
// Assertion macros used by the lexer back end (sclx_back).
`ifndef SCRIPT_LEXER_UNIT_DEFINES_SVH
`define SCRIPT_LEXER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SCLX_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("script lexer assertion failed");
`define SCLX_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("script lexer assertion failed");
`else
`define SCLX_ASSERT(name, clk, rst, prop)
`define SCLX_ASSERT_NEXT(name, clk, rst, pre, post)
`endif

`endif

// File: rtl/core/sclx_pkg.sv
package sclx_pkg;

   localparam int MAX_CODE_LEN_DEF = 65536;
   localparam int RES_MAX          = 4;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [4:0] KIND_IDENT   = 5'd0;
   localparam logic [4:0] KIND_BOOL    = 5'd1;
   localparam logic [4:0] KIND_NUMBER  = 5'd2;
   localparam logic [4:0] KIND_STRING  = 5'd3;
   localparam logic [4:0] KIND_EOL     = 5'd4;
   localparam logic [4:0] KIND_EOF     = 5'd5;
   localparam logic [4:0] KIND_CARET   = 5'd6;
   localparam logic [4:0] KIND_LPAREN  = 5'd7;
   localparam logic [4:0] KIND_RPAREN  = 5'd8;
   localparam logic [4:0] KIND_LBRACE  = 5'd9;
   localparam logic [4:0] KIND_RBRACE  = 5'd10;
   localparam logic [4:0] KIND_LSQUARE = 5'd11;
   localparam logic [4:0] KIND_RSQUARE = 5'd12;
   localparam logic [4:0] KIND_COMMA   = 5'd13;
   localparam logic [4:0] KIND_DOT     = 5'd14;
   localparam logic [4:0] KIND_QUEST   = 5'd15;
   localparam logic [4:0] KIND_COLON   = 5'd16;
   localparam logic [4:0] KIND_STAR    = 5'd17;
   localparam logic [4:0] KIND_SLASH   = 5'd18;
   localparam logic [4:0] KIND_PLUS    = 5'd19;
   localparam logic [4:0] KIND_MINUS   = 5'd20;
   localparam logic [4:0] KIND_OROR    = 5'd21;
   localparam logic [4:0] KIND_ANDAND  = 5'd22;
   localparam logic [4:0] KIND_EQEQ    = 5'd23;
   localparam logic [4:0] KIND_NOTEQ   = 5'd24;
   localparam logic [4:0] KIND_NOT     = 5'd25;
   localparam logic [4:0] KIND_GT      = 5'd26;
   localparam logic [4:0] KIND_GE      = 5'd27;
   localparam logic [4:0] KIND_LT      = 5'd28;
   localparam logic [4:0] KIND_LE      = 5'd29;
   localparam logic [4:0] KIND_ARROW   = 5'd30;
   localparam logic [4:0] KIND_ERROR   = 5'd31;

   localparam logic [3:0] KW_NONE  = 4'd0;
   localparam logic [3:0] KW_T     = 4'd1;
   localparam logic [3:0] KW_TR    = 4'd2;
   localparam logic [3:0] KW_TRU   = 4'd3;
   localparam logic [3:0] KW_TRUE  = 4'd4;
   localparam logic [3:0] KW_F     = 4'd5;
   localparam logic [3:0] KW_FA    = 4'd6;
   localparam logic [3:0] KW_FAL   = 4'd7;
   localparam logic [3:0] KW_FALS  = 4'd8;
   localparam logic [3:0] KW_FALSE = 4'd9;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_PAIR, MODE_PAREN, MODE_SWALLOW
   } scan_mode_type;

   typedef enum logic [1:0] {CLS_NONE, CLS_EOL, CLS_ENDER, CLS_OTHER} tok_class_type;

   typedef struct packed {
      logic [2:0]        count;
      logic [3:0] [4:0]  kind;
      logic [3:0] [15:0] start;
      logic [3:0] [15:0] len;
   } res_group_type;

   function automatic logic is_space(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_identch(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic logic is_cont(logic [7:0] c);
      return c == ")" || c == "}" || c == "]" || c == "," || c == "." || c == "?" ||
             c == ":" || c == "^" || c == "*" || c == "/" || c == "+" || c == "-" ||
             c == "|" || c == "&" || c == "=" || c == "!" || c == "<" || c == ">" ||
             c == "~";
   endfunction

   function automatic logic [4:0] single_kind(logic [7:0] c);
      unique case (c)
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         "[":     return KIND_LSQUARE;
         "]":     return KIND_RSQUARE;
         ",":     return KIND_COMMA;
         ".":     return KIND_DOT;
         "?":     return KIND_QUEST;
         ":":     return KIND_COLON;
         "^":     return KIND_CARET;
         "*":     return KIND_STAR;
         "/":     return KIND_SLASH;
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         default: return KIND_ERROR;
      endcase
   endfunction

   function automatic logic is_pair_lead(logic [7:0] c);
      return c == "|" || c == "&" || c == "=" || c == "!" || c == ">" || c == "<" ||
             c == "~";
   endfunction

   function automatic logic [7:0] pair_partner(logic [7:0] h);
      priority if (h == "|") return "|";
      else if (h == "&") return "&";
      else if (h == "~") return ">";
      else return "=";
   endfunction

   function automatic logic [4:0] pair_kind(logic [7:0] h);
      unique case (h)
         "|":     return KIND_OROR;
         "&":     return KIND_ANDAND;
         "=":     return KIND_EQEQ;
         "!":     return KIND_NOTEQ;
         ">":     return KIND_GE;
         "<":     return KIND_LE;
         default: return KIND_ARROW;
      endcase
   endfunction

   function automatic logic [4:0] pair_lone_kind(logic [7:0] h);
      unique case (h)
         "!":     return KIND_NOT;
         ">":     return KIND_GT;
         "<":     return KIND_LT;
         default: return KIND_ERROR;
      endcase
   endfunction

   function automatic logic [3:0] kw_next(logic [3:0] s, logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      unique case (s)
         KW_T:    return (l == "r") ? KW_TR : KW_NONE;
         KW_TR:   return (l == "u") ? KW_TRU : KW_NONE;
         KW_TRU:  return (l == "e") ? KW_TRUE : KW_NONE;
         KW_F:    return (l == "a") ? KW_FA : KW_NONE;
         KW_FA:   return (l == "l") ? KW_FAL : KW_NONE;
         KW_FAL:  return (l == "s") ? KW_FALS : KW_NONE;
         KW_FALS: return (l == "e") ? KW_FALSE : KW_NONE;
         default: return KW_NONE;
      endcase
   endfunction

endpackage

// File: rtl/core/sclx_front.sv
module sclx_front
   import sclx_pkg::*;
#(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    ch,
   input  logic          end_of_code,
   output logic          push,
   output res_group_type group
);

   localparam int DW = $clog2(MAX_CODE_LEN) + 1;
   localparam logic signed [DW-1:0] DEPTH_HI = DW'(MAX_CODE_LEN - 1);
   localparam logic signed [DW-1:0] DEPTH_LO = DW'(-MAX_CODE_LEN);

   scan_mode_type          mode_ff, mode_in;
   logic [7:0]             held_ff, held_in;
   logic [15:0]            begin_ff, begin_in;
   logic [15:0]            pos_ff, pos_in;
   logic signed [DW-1:0]   depth_ff, depth_in;
   tok_class_type          cls_ff, cls_in;
   logic                   pend_ff, pend_in;
   logic [3:0]             kw_ff, kw_in;
   res_group_type          group_c;

   function automatic res_group_type put(res_group_type g, logic [4:0] k, logic [15:0] s,
                                         logic [15:0] l);
      res_group_type r;
      r = g;
      if (g.count < 3'(RES_MAX)) begin
         r.kind[g.count[1:0]]  = k;
         r.start[g.count[1:0]] = s;
         r.len[g.count[1:0]]   = l;
         r.count               = g.count + 3'd1;
      end
      return r;
   endfunction

   function automatic tok_class_type cls_of(logic [4:0] k);
      if (k == KIND_EOL) return CLS_EOL;
      if (k <= KIND_STRING || k == KIND_CARET || k == KIND_RPAREN || k == KIND_RBRACE ||
          k == KIND_RSQUARE) return CLS_ENDER;
      return CLS_OTHER;
   endfunction

   function automatic logic signed [DW-1:0] dep_of(logic signed [DW-1:0] d, logic [4:0] k);
      if (k == KIND_LPAREN || k == KIND_LBRACE || k == KIND_LSQUARE) begin
         if (d < DEPTH_HI) return DW'(d + 1);
      end else if (k == KIND_RPAREN || k == KIND_RBRACE || k == KIND_RSQUARE) begin
         if (d > DEPTH_LO) return DW'(d - 1);
      end
      return d;
   endfunction

   always_comb begin
      scan_mode_type        m;
      logic [7:0]           h;
      logic [15:0]          tb;
      logic [15:0]          p;
      logic [15:0]          endp;
      tok_class_type        lc;
      logic                 pe;
      logic [3:0]           km;
      logic signed [DW-1:0] d;
      logic                 used;
      logic [4:0]           k;
      res_group_type        g;
      m    = mode_ff;
      h    = held_ff;
      tb   = begin_ff;
      p    = pos_ff;
      endp = pos_ff + 16'd1;
      lc   = cls_ff;
      pe   = pend_ff;
      km   = kw_ff;
      d    = depth_ff;
      used = 1'b0;
      g    = '0;
      k    = KIND_IDENT;

      unique case (m)
         MODE_IDENT: begin
            if (is_identch(ch)) begin
               km   = kw_next(km, ch);
               used = 1'b1;
            end else begin
               k  = (km == KW_TRUE || km == KW_FALSE) ? KIND_BOOL : KIND_IDENT;
               g  = put(g, k, tb, p - tb);
               lc = cls_of(k);
               d  = dep_of(d, k);
               m  = MODE_IDLE;
               if (k == KIND_IDENT && ch == "(" && !end_of_code) begin
                  m    = MODE_PAREN;
                  tb   = p;
                  used = 1'b1;
               end
            end
         end
         MODE_NUMBER: begin
            if (is_digit(ch)) begin
               used = 1'b1;
            end else begin
               g  = put(g, KIND_NUMBER, tb, p - tb);
               lc = cls_of(KIND_NUMBER);
               m  = MODE_IDLE;
            end
         end
         MODE_STRING: begin
            if (ch == "'") begin
               g  = put(g, KIND_STRING, tb, p - tb);
               lc = cls_of(KIND_STRING);
               m  = MODE_IDLE;
            end
            used = 1'b1;
         end
         MODE_PAIR: begin
            if (ch == pair_partner(h)) begin
               k    = pair_kind(h);
               g    = put(g, k, tb, 16'd2);
               lc   = cls_of(k);
               m    = MODE_IDLE;
               used = 1'b1;
            end else begin
               k = pair_lone_kind(h);
               if (k == KIND_ERROR) begin
                  g    = put(g, KIND_ERROR, tb, 16'd1);
                  m    = MODE_SWALLOW;
                  pe   = 1'b0;
                  used = 1'b1;
               end else begin
                  g  = put(g, k, tb, 16'd1);
                  lc = cls_of(k);
                  m  = MODE_IDLE;
               end
            end
         end
         MODE_PAREN: begin
            m = MODE_IDLE;
            if (ch == ")") begin
               used = 1'b1;
            end else begin
               g  = put(g, KIND_LPAREN, tb, 16'd1);
               lc = cls_of(KIND_LPAREN);
               d  = dep_of(d, KIND_LPAREN);
            end
         end
         MODE_SWALLOW: used = 1'b1;
         default: ;
      endcase

      if (!used && m == MODE_IDLE) begin
         if (is_space(ch)) begin
            if (ch == 8'h0a && !pe && lc == CLS_ENDER && d <= 0) begin
               pe = 1'b1;
               tb = p;
            end
         end else begin
            if (pe) begin
               pe = 1'b0;
               if (!is_cont(ch)) begin
                  g  = put(g, KIND_EOL, tb, 16'd0);
                  lc = CLS_EOL;
               end
            end
            if (is_alpha(ch) || ch == "_") begin
               m  = MODE_IDENT;
               tb = p;
               km = ((ch | 8'h20) == "t") ? KW_T : ((ch | 8'h20) == "f") ? KW_F : KW_NONE;
            end else if (is_digit(ch)) begin
               m  = MODE_NUMBER;
               tb = p;
            end else if (ch == "'") begin
               m  = MODE_STRING;
               tb = endp;
            end else if (is_pair_lead(ch)) begin
               m  = MODE_PAIR;
               h  = ch;
               tb = p;
            end else begin
               k = single_kind(ch);
               if (k == KIND_ERROR) begin
                  g  = put(g, KIND_ERROR, p, 16'd1);
                  m  = MODE_SWALLOW;
                  pe = 1'b0;
               end else begin
                  g  = put(g, k, p, 16'd1);
                  lc = cls_of(k);
                  d  = dep_of(d, k);
               end
            end
         end
      end

      if (end_of_code) begin
         unique case (m)
            MODE_IDENT: begin
               k = (km == KW_TRUE || km == KW_FALSE) ? KIND_BOOL : KIND_IDENT;
               g = put(g, k, tb, endp - tb);
            end
            MODE_NUMBER: g = put(g, KIND_NUMBER, tb, endp - tb);
            MODE_STRING: g = put(g, KIND_STRING, tb, endp - tb);
            MODE_PAIR: begin
               k = pair_lone_kind(h);
               g = put(g, k, tb, 16'd1);
               if (k == KIND_ERROR) m = MODE_SWALLOW;
            end
            MODE_PAREN: g = put(g, KIND_LPAREN, tb, 16'd1);
            default: ;
         endcase
         if (m != MODE_SWALLOW) begin
            if (pe) g = put(g, KIND_EOL, tb, 16'd0);
            g = put(g, KIND_EOF, endp, 16'd0);
         end
         mode_in  = MODE_IDLE;
         held_in  = '0;
         begin_in = '0;
         pos_in   = '0;
         depth_in = '0;
         cls_in   = CLS_NONE;
         pend_in  = 1'b0;
         kw_in    = KW_NONE;
      end else begin
         mode_in  = m;
         held_in  = h;
         begin_in = tb;
         pos_in   = endp;
         depth_in = d;
         cls_in   = lc;
         pend_in  = pe;
         kw_in    = km;
      end
      group_c = g;
   end

   always_comb begin
      group = group_c;
      push  = accept && group_c.count != 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         held_ff  <= '0;
         begin_ff <= '0;
         pos_ff   <= '0;
         depth_ff <= '0;
         cls_ff   <= CLS_NONE;
         pend_ff  <= 1'b0;
         kw_ff    <= KW_NONE;
      end else if (accept) begin
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         begin_ff <= begin_in;
         pos_ff   <= pos_in;
         depth_ff <= depth_in;
         cls_ff   <= cls_in;
         pend_ff  <= pend_in;
         kw_ff    <= kw_in;
      end
   end

endmodule

// File: rtl/core/sclx_queue.sv
module sclx_queue
   import sclx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  res_group_type push_data,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output res_group_type pop_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   res_group_type   entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [PW:0]     fill_ff, fill_in;

   assign full     = fill_ff == (PW+1)'(QUEUE_DEPTH);
   assign empty    = fill_ff == '0;
   assign pop_data = entry_ff[rd_ff];

   always_comb begin
      wr_in   = (push && wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(push);
      rd_in   = (pop && rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(pop);
      fill_in = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_data;
   end

endmodule

// File: rtl/core/sclx_back.sv
`include "script_lexer_unit_defines.svh"

module sclx_back
   import sclx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  res_group_type q_data,
   output logic          q_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output logic [4:0]    rsp_token_kind,
   output logic [15:0]   rsp_token_start,
   output logic [15:0]   rsp_token_length,
   output logic          rsp_last_of_run
);

   res_group_type cur_ff, cur_in;
   logic [1:0]    idx_ff, idx_in;
   logic          have_ff, have_in;
   logic          last;
   logic          xfer;
   logic          load;

   assign last  = {1'b0, idx_ff} == cur_ff.count - 3'd1;
   assign xfer  = rsp_pop && have_ff;
   assign load  = !q_empty && (!have_ff || (xfer && last));
   assign q_pop = load;

   assign rsp_empty        = !have_ff;
   assign rsp_token_kind   = cur_ff.kind[idx_ff];
   assign rsp_token_start  = cur_ff.start[idx_ff];
   assign rsp_token_length = cur_ff.len[idx_ff];
   assign rsp_last_of_run  = last;

   always_comb begin
      cur_in  = load ? q_data : cur_ff;
      idx_in  = load ? 2'd0 : (xfer ? idx_ff + 2'd1 : idx_ff);
      have_in = load ? 1'b1 : ((xfer && last) ? 1'b0 : have_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         have_ff <= have_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   `SCLX_ASSERT(a_group_nonempty, clock, reset, have_ff |-> cur_ff.count != 3'd0)
   `SCLX_ASSERT(a_index_in_group, clock, reset, have_ff |-> {1'b0, idx_ff} < cur_ff.count)
   `SCLX_ASSERT_NEXT(a_run_continues, clock, reset, xfer && !last, have_ff && idx_ff == $past(idx_ff) + 2'd1)

endmodule

// File: rtl/core/script_lexer_unit.sv
// Streaming script lexer. One character transfers per cycle on the request side while the
// result queue has room; the characters of one code run through the scanner in order and end
// with the one marked end_of_code. Each character yields zero to four tokens, which leave one
// per cycle on the response side while rsp_pop is high; the final token of a character is
// flagged by rsp_last_of_run. A character is scanned in the cycle it transfers; its tokens
// wait in a two-entry group queue, so a character that yields n tokens holds the response
// side until all n are popped, and req_full rises only when that queue is full.
module script_lexer_unit
   import sclx_pkg::*;
#(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_code,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);

   res_group_type front_group;
   res_group_type queue_group;
   logic          front_push;
   logic          queue_full;
   logic          queue_empty;
   logic          queue_pop;
   logic          accept;

   assign accept   = req_push && !queue_full;
   assign req_full = queue_full;

   sclx_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ch          (req_ch),
      .end_of_code (req_end_of_code),
      .push        (front_push),
      .group       (front_group)
   );

   sclx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_group),
      .pop       (queue_pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .pop_data  (queue_group)
   );

   sclx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (queue_empty),
      .q_data           (queue_group),
      .q_pop            (queue_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
